### rtl/core/spf_pkg.sv
// ----------------------------------------------------------------------------
// Stepper position follower package
// Item types, action and register codes, constants and the coil table.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int STEP_TENTHS   = 9;
  localparam int HOLD_PERIOD   = 127000;
  localparam int PERIOD_W      = 18;
  localparam int ANGLE_W       = 16;
  localparam int CFG_DATA_W    = 18;
  localparam int CFG_IDX_W     = 2;

  localparam logic [PERIOD_W-1:0]       PERIOD_RST = 18'd500;
  localparam logic signed [ANGLE_W-1:0] LOWER_RST  = -16'sd32768;
  localparam logic signed [ANGLE_W-1:0] UPPER_RST  = 16'sd32767;
  localparam logic signed [ANGLE_W-1:0] HOME_RST   = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] TARGET_RST = 16'sd900;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_TARGET = 2'd1,
    ACT_HOME   = 2'd2,
    ACT_NONE   = 2'd3
  } spf_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_LOWER  = 2'd1,
    REG_UPPER  = 2'd2,
    REG_HOME   = 2'd3
  } spf_reg_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [ANGLE_W-1:0] target_angle;
  } spf_in_t;

  typedef struct packed {
    logic [3:0]                coil_pattern;
    logic                      full_drive;
    logic                      stepped;
    logic signed [ANGLE_W-1:0] position;
    logic signed [ANGLE_W-1:0] target;
  } spf_out_t;

  typedef struct packed {
    logic full;
    logic pop;
  } spf_buf_stat_t;

  function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'd8;
      3'd1:    pat = 4'd10;
      3'd2:    pat = 4'd2;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd4;
      3'd5:    pat = 4'd5;
      3'd6:    pat = 4'd1;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

### rtl/core/spf_datapath.sv
// ----------------------------------------------------------------------------
// Stepper position follower datapath
// Holds the registers and motor state and works out one result per item.
// ----------------------------------------------------------------------------
module spf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                item_en,
  input  spf_pkg::spf_in_t                    item,
  output spf_pkg::spf_out_t                   result
);
  import spf_pkg::*;

  localparam logic signed [ANGLE_W:0]  STEP_S = (ANGLE_W+1)'(STEP_TENTHS);
  localparam logic [PERIOD_W-1:0]      HOLD_P = PERIOD_W'(HOLD_PERIOD);
  localparam logic signed [ANGLE_W:0]  MAX_S  = (ANGLE_W+1)'((1 << (ANGLE_W-1)) - 1);
  localparam logic signed [ANGLE_W:0]  MIN_S  = -(MAX_S + (ANGLE_W+1)'(1));

  logic [PERIOD_W-1:0]       period_r;
  logic signed [ANGLE_W-1:0] lower_r, upper_r, home_r;
  logic signed [ANGLE_W-1:0] pos_r, pos_nxt, tgt_r, tgt_nxt;
  logic [2:0]                phase_r, phase_nxt;
  logic [PERIOD_W-1:0]       tick_r, tick_nxt, tick_inc;
  logic                      drive_r, drive_nxt;
  logic                      moved;
  logic signed [ANGLE_W:0]   err, pos_ext, pos_step;
  logic signed [ANGLE_W-1:0] cfg_angle;

  assign cfg_angle = cfg_wdata[ANGLE_W-1:0];
  assign tick_inc  = tick_r + PERIOD_W'(1);
  assign pos_ext   = (ANGLE_W+1)'(pos_r);
  assign err       = pos_ext - (ANGLE_W+1)'(tgt_r);

  always_comb begin
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    drive_nxt = drive_r;
    moved     = 1'b0;
    pos_step  = pos_ext;
    case (spf_action_t'(item.action))
      ACT_TICK: begin
        tick_nxt = tick_inc;
        if (tick_inc >= period_r) begin
          tick_nxt = '0;
          if (err > STEP_S) begin
            moved     = 1'b1;
            phase_nxt = phase_r - 3'd1;
            pos_step  = pos_ext - STEP_S;
          end else if (err < -STEP_S) begin
            moved     = 1'b1;
            phase_nxt = phase_r + 3'd1;
            pos_step  = pos_ext + STEP_S;
          end
          if (pos_step > MAX_S) begin
            pos_nxt = MAX_S[ANGLE_W-1:0];
          end else if (pos_step < MIN_S) begin
            pos_nxt = MIN_S[ANGLE_W-1:0];
          end else begin
            pos_nxt = pos_step[ANGLE_W-1:0];
          end
          drive_nxt = moved && (period_r <= HOLD_P);
        end
      end
      ACT_TARGET: begin
        if (item.target_angle > upper_r) begin
          tgt_nxt = upper_r;
        end else if (item.target_angle < lower_r) begin
          tgt_nxt = lower_r;
        end else begin
          tgt_nxt = item.target_angle;
        end
      end
      ACT_HOME: begin
        tgt_nxt = home_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      lower_r  <= LOWER_RST;
      upper_r  <= UPPER_RST;
      home_r   <= HOME_RST;
      pos_r    <= '0;
      tgt_r    <= TARGET_RST;
      phase_r  <= '0;
      tick_r   <= '0;
      drive_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (spf_reg_t'(cfg_index))
        REG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_LOWER:  lower_r  <= cfg_angle;
        REG_UPPER:  upper_r  <= cfg_angle;
        REG_HOME: begin
          home_r <= cfg_angle;
          pos_r  <= cfg_angle;
        end
        default: begin
        end
      endcase
    end else if (item_en) begin
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      drive_r <= drive_nxt;
    end
  end

  always_comb begin
    result.coil_pattern = coil_lookup(phase_nxt);
    result.full_drive   = drive_nxt;
    result.stepped      = moved;
    result.position     = pos_nxt;
    result.target       = tgt_nxt;
  end

endmodule

### rtl/core/spf_out_buf.sv
// ----------------------------------------------------------------------------
// Stepper position follower result buffer
// Two-entry result queue that keeps the input side moving during stalls.
// ----------------------------------------------------------------------------
module spf_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  spf_pkg::spf_out_t      push_item,
  input  logic                   out_stall,
  output logic                   out_valid,
  output spf_pkg::spf_out_t      out_item,
  output spf_pkg::spf_buf_stat_t stat
);
  import spf_pkg::*;

  spf_out_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = mem_r[rd_ptr_r];
  assign stat.full = (cnt_r == 2'd2);
  assign stat.pop  = pop;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/core/stepper_half_step_position_follower.sv
// ----------------------------------------------------------------------------
// Stepper half-step position follower
// An accepted item is registered in stage one, and its result then in the result queue.
// Throughput: one item per cycle while the result queue has room; in_stall holds the input otherwise.
// A two-entry result queue lets items keep arriving while a result is stalled, until the queue fills.
// Reset is synchronous and active low; the block takes items right after it.
// ----------------------------------------------------------------------------
module stepper_half_step_position_follower (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spf_pkg::spf_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spf_pkg::spf_out_t               out_item,
  input  logic                            cfg_we,
  input  logic [spf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import spf_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  spf_in_t       s1_item_r;
  logic          s1_adv, in_acc;
  spf_out_t      result;
  spf_buf_stat_t stat;

  assign s1_adv   = s1_valid_r && (!stat.full || stat.pop);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  spf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_en   (s1_adv),
    .item      (s1_item_r),
    .result    (result)
  );

  spf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_adv),
    .push_item (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

endmodule

### bench/stepper_half_step_position_follower_tb.sv
// ----------------------------------------------------------------------------
// Stepper half-step position follower testbench
// Drives tick, set-target, home and unused actions through the valid/stall
// input channel while the result channel stalls at random. A scoreboard
// keeps its own copy of the motor state and the registers, predicts one
// result per accepted item and compares every result field by field. The
// run steps through several register settings: zero and one-tick periods,
// crossed limits, extreme home angles, and a period too long to reach a
// step decision within its run.
// ----------------------------------------------------------------------------
module stepper_half_step_position_follower_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  class follower_scoreboard;
    logic [PERIOD_W-1:0]       period;
    logic signed [ANGLE_W-1:0] lower;
    logic signed [ANGLE_W-1:0] upper;
    logic signed [ANGLE_W-1:0] home;
    logic signed [ANGLE_W-1:0] position;
    logic signed [ANGLE_W-1:0] target;
    logic [2:0]                phase;
    logic [PERIOD_W-1:0]       ticks;
    logic                      full_drive;
    spf_out_t                  expected_q[$];
    int                        errors;
    int                        items_seen;
    int                        results_seen;
    int                        steps_seen;

    function new();
      period     = PERIOD_RST;
      lower      = LOWER_RST;
      upper      = UPPER_RST;
      home       = HOME_RST;
      position   = '0;
      target     = TARGET_RST;
      phase      = '0;
      ticks      = '0;
      full_drive = 1'b0;
      errors     = 0;
      items_seen = 0;
      results_seen = 0;
      steps_seen = 0;
    endfunction

    function void write_reg(spf_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PERIOD: period = data[PERIOD_W-1:0];
        REG_LOWER:  lower = data[ANGLE_W-1:0];
        REG_UPPER:  upper = data[ANGLE_W-1:0];
        REG_HOME: begin
          home = data[ANGLE_W-1:0];
          position = data[ANGLE_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void note_item(spf_in_t it);
      logic signed [ANGLE_W-1:0] req;
      spf_out_t                  exp;
      int                        err;
      int                        nv;
      logic                      moved;
      req = it.target_angle;
      moved = 1'b0;
      items_seen++;
      case (spf_action_t'(it.action))
        ACT_TICK: begin
          ticks = ticks + 1'b1;
          if (ticks >= period) begin
            err = int'(position) - int'(target);
            if (err > STEP_TENTHS) begin
              phase = phase - 3'd1;
              nv = int'(position) - STEP_TENTHS;
              position = (nv < -32768) ? -16'sd32768 : ANGLE_W'(nv);
              moved = 1'b1;
            end else if (err < -STEP_TENTHS) begin
              phase = phase + 3'd1;
              nv = int'(position) + STEP_TENTHS;
              position = (nv > 32767) ? 16'sd32767 : ANGLE_W'(nv);
              moved = 1'b1;
            end
            full_drive = moved && (period <= HOLD_PERIOD);
            ticks = '0;
          end
        end
        ACT_TARGET: begin
          if (req > upper) target = upper;
          else if (req < lower) target = lower;
          else target = req;
        end
        ACT_HOME: target = home;
        default: ;
      endcase
      case (phase)
        3'd0:    exp.coil_pattern = 4'd8;
        3'd1:    exp.coil_pattern = 4'd10;
        3'd2:    exp.coil_pattern = 4'd2;
        3'd3:    exp.coil_pattern = 4'd6;
        3'd4:    exp.coil_pattern = 4'd4;
        3'd5:    exp.coil_pattern = 4'd5;
        3'd6:    exp.coil_pattern = 4'd1;
        default: exp.coil_pattern = 4'd9;
      endcase
      exp.full_drive = full_drive;
      exp.stepped    = moved;
      exp.position   = position;
      exp.target     = target;
      expected_q.push_back(exp);
    endfunction

    function void check_field(string name, logic signed [31:0] exp, logic signed [31:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(spf_out_t got);
      spf_out_t exp;
      results_seen++;
      if (got.stepped === 1'b1) steps_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      exp = expected_q.pop_front();
      check_field("coil_pattern", exp.coil_pattern, got.coil_pattern);
      check_field("full_drive", exp.full_drive, got.full_drive);
      check_field("stepped", exp.stepped, got.stepped);
      check_field("position", exp.position, got.position);
      check_field("target", exp.target, got.target);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  spf_in_t                in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  spf_out_t               out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  follower_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int settings_used = 0;

  stepper_half_step_position_follower i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Handshakes are sampled at the falling edge: nothing changes between it
  // and the next rising edge, where the transfer takes place.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) sb.check_result(out_item);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
        $display("stepper_half_step_position_follower_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic signed [ANGLE_W-1:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return ANGLE_W'(v);
  endfunction

  function automatic spf_in_t make_item(spf_action_t act, logic signed [ANGLE_W-1:0] ang);
    spf_in_t it;
    it.action = act;
    it.target_angle = ang;
    return it;
  endfunction

  function automatic spf_in_t random_item();
    int r;
    logic signed [ANGLE_W-1:0] ang;
    r = $urandom_range(99);
    ang = ANGLE_W'($urandom);
    if (r < 68) return make_item(ACT_TICK, ang);
    if (r < 88) begin
      case ($urandom_range(3))
        0: ;
        1: ang = clip16(int'(sb.position) + int'($urandom_range(300)) - 150);
        2: ang = clip16(int'(sb.position) + int'($urandom_range(24)) - 12);
        default: begin
          case ($urandom_range(5))
            0: ang = -16'sd32768;
            1: ang = 16'sd32767;
            2: ang = sb.lower;
            3: ang = sb.upper;
            4: ang = clip16(int'(sb.lower) - 1);
            default: ang = clip16(int'(sb.upper) + 1);
          endcase
        end
      endcase
      return make_item(ACT_TARGET, ang);
    end
    if (r < 95) return make_item(ACT_HOME, ang);
    return make_item(ACT_NONE, ang);
  endfunction

  task automatic send_item(spf_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    sb.note_item(it);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (4) @(posedge clk);
    settings_used++;
  endtask

  task automatic program_reg(spf_reg_t idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    sb.write_reg(idx, CFG_DATA_W'(value));
    @(posedge clk);
  endtask

  task automatic run_random(int n, bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_drained();
      send_item(random_item());
    end
  endtask

  task automatic run_ticks(int n);
    for (int i = 0; i < n; i++) send_item(make_item(ACT_TICK, ANGLE_W'($urandom)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 76;
    send_item(make_item(ACT_TICK, 16'sh1234));
    send_item(make_item(ACT_NONE, 16'shEDCB));
    settle();
    program_reg(REG_PERIOD, 1);
    program_reg(REG_LOWER, -32768);
    program_reg(REG_UPPER, 32767);
    cfg_we <= 1'b0;
    @(posedge clk);

    // Step down from phase zero wraps to phase seven, then back up past it.
    send_item(make_item(ACT_TARGET, -16'sd100));
    run_ticks(2);
    send_item(make_item(ACT_TARGET, 16'sd32767));
    run_ticks(3);
    send_item(make_item(ACT_TARGET, -16'sd32768));
    run_ticks(1);
    send_item(make_item(ACT_TARGET, clip16(int'(sb.position) + STEP_TENTHS)));
    run_ticks(1);
    send_item(make_item(ACT_TARGET, clip16(int'(sb.position) - STEP_TENTHS)));
    run_ticks(1);
    send_item(make_item(ACT_TARGET, clip16(int'(sb.position) + STEP_TENTHS + 1)));
    run_ticks(1);
    send_item(make_item(ACT_NONE, 16'sh7FFF));
    send_item(make_item(ACT_NONE, -16'sd32768));
    send_item(make_item(ACT_HOME, 16'sh5555));
    run_ticks(2);

    settle();
    program_reg(REG_HOME, -500);
    cfg_we <= 1'b0;
    run_random(300, 1'b1);

    settle();
    program_reg(REG_PERIOD, 0);
    program_reg(REG_LOWER, -200);
    program_reg(REG_UPPER, 300);
    program_reg(REG_HOME, 50);
    cfg_we <= 1'b0;
    run_random(300, 1'b0);

    send_idle_pct = 76;
    recv_idle_pct = 8;
    settle();
    program_reg(REG_LOWER, 100);
    program_reg(REG_UPPER, -100);
    program_reg(REG_PERIOD, 2);
    cfg_we <= 1'b0;
    run_random(250, 1'b0);

    settle();
    program_reg(REG_LOWER, -32768);
    program_reg(REG_UPPER, 32767);
    program_reg(REG_HOME, -32768);
    program_reg(REG_PERIOD, 3);
    cfg_we <= 1'b0;
    run_random(300, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    program_reg(REG_HOME, 32767);
    program_reg(REG_LOWER, -1000);
    program_reg(REG_PERIOD, 1);
    cfg_we <= 1'b0;
    run_random(250, 1'b0);

    settle();
    program_reg(REG_PERIOD, 262143);
    cfg_we <= 1'b0;
    run_random(150, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d items over %0d register settings with random stalls on both sides.",
             sb.items_seen, settings_used);
    $display("%0d results checked, %0d of them half steps.", sb.results_seen, sb.steps_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("stepper_half_step_position_follower_tb: done, clean");
    end else begin
      $display("stepper_half_step_position_follower_tb: done, errors");
    end
    $finish;
  end

endmodule
